// ===== rtl/core/tkss_pkg.sv =====
// Shared types and codes for the sorted top-K score table.
`timescale 1ns / 1ps

package tkss_pkg;

    // Defaults for the top-level parameters
    localparam int TABLE_DEPTH_DEF    = 10;
    localparam int CATEGORY_COUNT_DEF = 4;

    // Field widths fixed by the interface
    localparam int FUNC_W  = 2;
    localparam int CAT_W   = 2;
    localparam int SCORE_W = 64;
    localparam int TAG_W   = 16;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 4;

    // Operation codes carried on func
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_CLEAR  = 2'd1,
        FUNC_READ   = 2'd2
    } func_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_REPORT
    } state_t;

    // One stored table entry
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [TAG_W-1:0]   tag;
    } entry_t;

    // Control bundle from the sequencer
    typedef struct packed {
        logic busy;
        logic insert_en;
        logic clear_en;
        logic report_en;
    } ctrl_t;

endpackage

// ===== rtl/core/top_k_sorted_score_table.sv =====
// Top level of the per-category sorted top-K score table.
`timescale 1ns / 1ps

// Usage
// One command channel: an operation is taken at a rising edge with start high
// and busy low. func selects insert, clear of all tables, read of one rank, or a report only.
// Every transaction gives one result, shown for a single cycle with done high;
// the receiver must take it then, as there is no way to hold it off.
// Timing: done rises as busy drops, so the next transaction can be taken while
// the result is shown; no new transaction is taken while one is in progress.
// The pace is set by the update step of the cell chain: the accepting edge
// registers the command, every rank then compares and shifts in parallel in the
// update state, the report is registered from the updated tables in the report
// state, and the result is shown in the idle state.
// Each cell of the chain holds one rank of every category and passes its entry
// and compare result to the next rank down.
// Reset empties every table (all counts zero); stored scores keep no reset
// value and are never shown until written.

module top_k_sorted_score_table #(
    parameter int TABLE_DEPTH    = tkss_pkg::TABLE_DEPTH_DEF,
    parameter int CATEGORY_COUNT = tkss_pkg::CATEGORY_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tkss_pkg::FUNC_W-1:0]    func,
    input  logic [tkss_pkg::CAT_W-1:0]     category,
    input  logic [tkss_pkg::SCORE_W-1:0]   score,
    input  logic [tkss_pkg::TAG_W-1:0]     tag,
    input  logic [tkss_pkg::SLOT_W-1:0]    slot,
    output logic                           done,
    output logic [tkss_pkg::SCORE_W-1:0]   threshold,
    output logic [tkss_pkg::COUNT_W-1:0]   entry_count,
    output logic                           kept,
    output logic                           entry_valid,
    output logic [tkss_pkg::SCORE_W-1:0]   entry_score,
    output logic [tkss_pkg::TAG_W-1:0]     entry_tag
);
    import tkss_pkg::*;

    localparam int CAT_IDX_W = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1;
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic [FUNC_W-1:0]    func_reg;
    logic [CAT_IDX_W-1:0] cat_reg;
    logic                 cat_ok_reg;
    logic [SLOT_W-1:0]    slot_reg;
    entry_t               new_reg;
    logic                 kept_reg;

    logic [CNT_W-1:0] counts_reg  [CATEGORY_COUNT];
    logic [CNT_W-1:0] counts_next [CATEGORY_COUNT];
    logic [CNT_W-1:0] cnt_sel;

    entry_t cell_entry [TABLE_DEPTH];
    logic   cell_le    [TABLE_DEPTH];
    entry_t rd_entry;
    logic   rd_valid;
    logic   is_full;

    logic                 done_reg;
    logic [SCORE_W-1:0]   threshold_reg;
    logic [COUNT_W-1:0]   entry_count_reg;
    logic                 kept_out_reg;
    logic                 entry_valid_reg;
    logic [SCORE_W-1:0]   entry_score_reg;
    logic [TAG_W-1:0]     entry_tag_reg;

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Advance through command, update and report
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (start) state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_REPORT;
            ST_REPORT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Decode sequencer outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:   ctrl.busy = 1'b0;
            ST_EXEC:
            begin
                ctrl.busy      = 1'b1;
                ctrl.insert_en = (func_reg == FUNC_INSERT) && cat_ok_reg;
                ctrl.clear_en  = (func_reg == FUNC_CLEAR);
            end
            ST_REPORT:
            begin
                ctrl.busy      = 1'b1;
                ctrl.report_en = 1'b1;
            end
            default:   ctrl = '0;
        endcase
    end

    assign busy = ctrl.busy;

    // Hold the command of the accepted transaction
    always_ff @(posedge clk)
    begin
        if (start && !ctrl.busy)
        begin
            func_reg      <= func;
            cat_reg       <= CAT_IDX_W'(category);
            cat_ok_reg    <= int'(category) < CATEGORY_COUNT;
            slot_reg      <= slot;
            new_reg.score <= score;
            new_reg.tag   <= tag;
        end
    end

    assign cnt_sel = counts_reg[cat_reg];

    // Chain of rank cells; rank zero has no neighbour above
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        entry_t prev_entry;
        logic   prev_le;

        if (i == 0)
        begin : g_head
            assign prev_entry = new_reg;
            assign prev_le    = 1'b0;
        end
        else
        begin : g_link
            assign prev_entry = cell_entry[i-1];
            assign prev_le    = cell_le[i-1];
        end

        tkss_cell #(
            .CATEGORY_COUNT (CATEGORY_COUNT),
            .TABLE_DEPTH    (TABLE_DEPTH),
            .INDEX          (i),
            .CAT_IDX_W      (CAT_IDX_W),
            .CNT_W          (CNT_W)
        ) u_cell (
            .clk        (clk),
            .insert_en  (ctrl.insert_en),
            .cat_idx    (cat_reg),
            .count      (cnt_sel),
            .new_entry  (new_reg),
            .prev_entry (prev_entry),
            .prev_le    (prev_le),
            .entry      (cell_entry[i]),
            .le         (cell_le[i])
        );
    end

    assign is_full = (cnt_sel == CNT_W'(TABLE_DEPTH));

    // Update fill counts: grow on a kept insert into a table that is not full, drop all on clear
    always_comb
    begin
        for (int c = 0; c < CATEGORY_COUNT; c++)
            counts_next[c] = counts_reg[c];
        if (ctrl.clear_en)
        begin
            for (int c = 0; c < CATEGORY_COUNT; c++)
                counts_next[c] = '0;
        end
        else if (ctrl.insert_en && cell_le[TABLE_DEPTH-1] && !is_full)
            counts_next[cat_reg] = cnt_sel + CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CATEGORY_COUNT; c++)
                counts_reg[c] <= '0;
        end
        else
        begin
            for (int c = 0; c < CATEGORY_COUNT; c++)
                counts_reg[c] <= counts_next[c];
        end
    end

    // Hold whether the insert entered the table
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
            kept_reg <= ctrl.insert_en && cell_le[TABLE_DEPTH-1];
    end

    // Select the read rank from the chain
    always_comb
    begin
        rd_entry = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (int'(slot_reg) == i)
                rd_entry = cell_entry[i];
        end
    end

    assign rd_valid = (func_reg == FUNC_READ) && cat_ok_reg && (int'(slot_reg) < int'(cnt_sel));

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctrl.report_en;
    end

    // Register the report from the updated tables
    always_ff @(posedge clk)
    begin
        if (ctrl.report_en)
        begin
            threshold_reg   <= (cat_ok_reg && is_full) ? cell_entry[TABLE_DEPTH-1].score : '0;
            entry_count_reg <= cat_ok_reg ? COUNT_W'(cnt_sel) : '0;
            kept_out_reg    <= kept_reg;
            entry_valid_reg <= rd_valid;
            entry_score_reg <= rd_valid ? rd_entry.score : '0;
            entry_tag_reg   <= rd_valid ? rd_entry.tag : '0;
        end
    end

    assign done        = done_reg;
    assign threshold   = threshold_reg;
    assign entry_count = entry_count_reg;
    assign kept        = kept_out_reg;
    assign entry_valid = entry_valid_reg;
    assign entry_score = entry_score_reg;
    assign entry_tag   = entry_tag_reg;

    // A result only follows the report step
    a_done_after_report: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_REPORT))
        else $error("result strobe without a report step");

    // busy only drops as a result is shown
    a_busy_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // A kept insert leaves a non-empty table
    a_kept_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && kept) |-> (entry_count != '0))
        else $error("kept insert reported with an empty table");

    // Fill count of the addressed category never passes the table depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_IDLE) && cat_ok_reg) |-> (int'(cnt_sel) <= TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // A valid read needs a non-zero count and no kept flag
    a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (done && entry_valid) |-> (!kept && (entry_count != '0)))
        else $error("inconsistent read result flags");

endmodule

// ===== rtl/core/tkss_cell.sv =====
// One rank of the sorted table chain, holding that rank for every category.
`timescale 1ns / 1ps

module tkss_cell #(
    parameter int CATEGORY_COUNT = tkss_pkg::CATEGORY_COUNT_DEF,
    parameter int TABLE_DEPTH    = tkss_pkg::TABLE_DEPTH_DEF,
    parameter int INDEX          = 0,
    parameter int CAT_IDX_W      = (CATEGORY_COUNT > 1) ? $clog2(CATEGORY_COUNT) : 1,
    parameter int CNT_W          = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 insert_en,
    input  logic [CAT_IDX_W-1:0] cat_idx,
    input  logic [CNT_W-1:0]     count,
    input  tkss_pkg::entry_t     new_entry,
    input  tkss_pkg::entry_t     prev_entry,
    input  logic                 prev_le,
    output tkss_pkg::entry_t     entry,
    output logic                 le
);
    import tkss_pkg::*;

    entry_t store_reg [CATEGORY_COUNT];
    logic   valid;

    // Look up this rank of the addressed category
    assign entry = store_reg[cat_idx];
    assign valid = INDEX < int'(count);

    // New score ranks at or ahead of this entry
    assign le = !(valid && (entry.score > new_entry.score));

    // Take the neighbour's entry on a shift, or the new one at the insert point
    always_ff @(posedge clk)
    begin
        if (insert_en)
        begin
            if (prev_le)
                store_reg[cat_idx] <= prev_entry;
            else if (le)
                store_reg[cat_idx] <= new_entry;
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the per-category sorted top-K score table.
`timescale 1ns / 1ps

module testbench;
    import tkss_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;
    localparam int CATS  = CATEGORY_COUNT_DEF;
    localparam logic [FUNC_W-1:0]  FUNC_UNUSED = 2'd3;
    localparam logic [SCORE_W-1:0] SCORE_MAX   = '1;
    localparam int RANDOM_OPS = 1080;

    // One report as the block shows it on its result ports
    typedef struct packed {
        logic [SCORE_W-1:0] threshold;
        logic [COUNT_W-1:0] count;
        logic               kept;
        logic               valid;
        logic [SCORE_W-1:0] escore;
        logic [TAG_W-1:0]   etag;
    } report_t;

    // One directed command, with its report typed in where it is obvious
    typedef struct packed {
        logic [FUNC_W-1:0]  fn;
        logic [CAT_W-1:0]   cat;
        logic [SCORE_W-1:0] sc;
        logic [TAG_W-1:0]   tg;
        logic [SLOT_W-1:0]  sl;
        logic               typed;
        report_t            want;
    } op_row_t;

    localparam report_t NO_REPORT = '0;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [FUNC_W-1:0]  func = FUNC_READ;
    logic [CAT_W-1:0]   category = '0;
    logic [SCORE_W-1:0] score = '0;
    logic [TAG_W-1:0]   tag = '0;
    logic [SLOT_W-1:0]  slot = '0;
    logic               busy;
    logic               done;
    logic [SCORE_W-1:0] threshold;
    logic [COUNT_W-1:0] entry_count;
    logic               kept;
    logic               entry_valid;
    logic [SCORE_W-1:0] entry_score;
    logic [TAG_W-1:0]   entry_tag;

    // Shadow copy of the ranked tables
    logic [SCORE_W-1:0] rank_score [CATS][DEPTH];
    logic [TAG_W-1:0]   rank_tag   [CATS][DEPTH];
    int                 fill       [CATS];

    report_t pending_reports [$];
    op_row_t directed_ops [0:23];
    int      errors = 0;
    int      n_inserts = 0;
    int      n_kept = 0;
    int      n_refused = 0;
    int      n_hits = 0;
    int      n_clears = 0;

    top_k_sorted_score_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .category    (category),
        .score       (score),
        .tag         (tag),
        .slot        (slot),
        .done        (done),
        .threshold   (threshold),
        .entry_count (entry_count),
        .kept        (kept),
        .entry_valid (entry_valid),
        .entry_score (entry_score),
        .entry_tag   (entry_tag)
    );

    always #4 clk = ~clk;

    // Apply one command to the shadow tables and return the report it gives
    function automatic report_t update_rank_tables(input logic [FUNC_W-1:0] fn,
                                                   input logic [CAT_W-1:0] cat,
                                                   input logic [SCORE_W-1:0] sc,
                                                   input logic [TAG_W-1:0] tg,
                                                   input logic [SLOT_W-1:0] sl);
        report_t r;
        int      pos;
        int      n;
        int      i;
        bit      cat_ok;
        r = '0;
        cat_ok = (int'(cat) < CATS);
        case (fn)
            FUNC_INSERT:
            begin
                if (cat_ok)
                begin
                    n = fill[cat];
                    pos = 0;
                    while (pos < n && rank_score[cat][pos] > sc)
                        pos++;
                    if (pos < DEPTH)
                    begin
                        // drop the last entry of a full table
                        if (n >= DEPTH)
                            n = DEPTH - 1;
                        for (i = n; i > pos; i--)
                        begin
                            rank_score[cat][i] = rank_score[cat][i-1];
                            rank_tag[cat][i]   = rank_tag[cat][i-1];
                        end
                        rank_score[cat][pos] = sc;
                        rank_tag[cat][pos]   = tg;
                        fill[cat] = n + 1;
                        r.kept = 1'b1;
                    end
                end
            end
            FUNC_CLEAR:
            begin
                for (i = 0; i < CATS; i++)
                    fill[i] = 0;
            end
            FUNC_READ:
            begin
                if (cat_ok && int'(sl) < fill[cat])
                begin
                    r.valid  = 1'b1;
                    r.escore = rank_score[cat][sl];
                    r.etag   = rank_tag[cat][sl];
                end
            end
            default:
            begin
            end
        endcase
        if (cat_ok)
        begin
            r.count = fill[cat][COUNT_W-1:0];
            if (fill[cat] >= DEPTH)
                r.threshold = rank_score[cat][DEPTH-1];
        end
        return r;
    endfunction

    // Present one command, hold it until taken, then log the expected report
    task automatic issue_op(input logic [FUNC_W-1:0] fn, input logic [CAT_W-1:0] cat,
                            input logic [SCORE_W-1:0] sc, input logic [TAG_W-1:0] tg,
                            input logic [SLOT_W-1:0] sl, input logic typed,
                            input report_t want);
        report_t r;
        start    <= 1'b1;
        func     <= fn;
        category <= cat;
        score    <= sc;
        tag      <= tg;
        slot     <= sl;
        do
            @(posedge clk);
        while (busy);
        r = update_rank_tables(fn, cat, sc, tg, sl);
        if (fn == FUNC_INSERT)
        begin
            n_inserts++;
            if (r.kept)
                n_kept++;
            else
                n_refused++;
        end
        if (r.valid)
            n_hits++;
        if (fn == FUNC_CLEAR)
            n_clears++;
        pending_reports.insert(pending_reports.size(), typed ? want : r);
    endtask

    // Lower start and let the given number of cycles pass
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // Wait until every outstanding report has come back
    task automatic drain_reports();
        if (pending_reports.size() != 0)
        begin
            start <= 1'b0;
            while (pending_reports.size() != 0)
                @(posedge clk);
        end
    endtask

    // Check each report against the oldest expectation
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && done)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("report with no transaction outstanding");
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (threshold !== want.threshold)
                begin
                    $error("threshold: expected %0h, got %0h", want.threshold, threshold);
                    errors++;
                end
                if (entry_count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, entry_count);
                    errors++;
                end
                if (kept !== want.kept)
                begin
                    $error("kept: expected %0b, got %0b", want.kept, kept);
                    errors++;
                end
                if (entry_valid !== want.valid)
                begin
                    $error("entry_valid: expected %0b, got %0b", want.valid, entry_valid);
                    errors++;
                end
                if (entry_score !== want.escore)
                begin
                    $error("entry_score: expected %0h, got %0h", want.escore, entry_score);
                    errors++;
                end
                if (entry_tag !== want.etag)
                begin
                    $error("entry_tag: expected %0h, got %0h", want.etag, entry_tag);
                    errors++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int                 k;
        int                 pick;
        int                 guard;
        int                 gap;
        bit                 no_idle;
        logic [FUNC_W-1:0]  fn;
        logic [SCORE_W-1:0] sc;
        logic [SLOT_W-1:0]  sl;

        for (k = 0; k < CATS; k++)
            fill[k] = 0;

        // Directed rows: empty tables, extremes, ties, full-table refusal, clear
        directed_ops[0] = '{FUNC_READ, 2'd0, 64'd0, 16'd0, 4'd0, 1'b1, NO_REPORT};
        directed_ops[1] = '{FUNC_UNUSED, 2'd3, SCORE_MAX, 16'hFFFF, 4'hF, 1'b1, NO_REPORT};
        directed_ops[2] = '{FUNC_INSERT, 2'd0, SCORE_MAX, 16'hFFFF, 4'd0, 1'b1,
                            '{64'd0, 4'd1, 1'b1, 1'b0, 64'd0, 16'd0}};
        directed_ops[3] = '{FUNC_INSERT, 2'd0, 64'd0, 16'd0, 4'd0, 1'b1,
                            '{64'd0, 4'd2, 1'b1, 1'b0, 64'd0, 16'd0}};
        directed_ops[4] = '{FUNC_READ, 2'd0, 64'd0, 16'd0, 4'd0, 1'b1,
                            '{64'd0, 4'd2, 1'b0, 1'b1, SCORE_MAX, 16'hFFFF}};
        directed_ops[5] = '{FUNC_READ, 2'd0, 64'd0, 16'd0, 4'd1, 1'b1,
                            '{64'd0, 4'd2, 1'b0, 1'b1, 64'd0, 16'd0}};
        directed_ops[6] = '{FUNC_READ, 2'd0, 64'd0, 16'd0, 4'hF, 1'b1,
                            '{64'd0, 4'd2, 1'b0, 1'b0, 64'd0, 16'd0}};
        // fill category 1 with equal scores
        for (k = 0; k < DEPTH; k++)
            directed_ops[7 + k] = '{FUNC_INSERT, 2'd1, 64'd100, 16'(k + 1), 4'd0, 1'b0,
                                    NO_REPORT};
        directed_ops[17] = '{FUNC_INSERT, 2'd1, 64'd99, 16'h1234, 4'd0, 1'b1,
                             '{64'd100, 4'd10, 1'b0, 1'b0, 64'd0, 16'd0}};
        directed_ops[18] = '{FUNC_INSERT, 2'd1, 64'd100, 16'hAAAA, 4'd0, 1'b1,
                             '{64'd100, 4'd10, 1'b1, 1'b0, 64'd0, 16'd0}};
        directed_ops[19] = '{FUNC_READ, 2'd1, 64'd0, 16'd0, 4'd0, 1'b0, NO_REPORT};
        directed_ops[20] = '{FUNC_READ, 2'd1, 64'd0, 16'd0, 4'd9, 1'b0, NO_REPORT};
        directed_ops[21] = '{FUNC_UNUSED, 2'd1, 64'd0, 16'd0, 4'd0, 1'b1,
                             '{64'd100, 4'd10, 1'b0, 1'b0, 64'd0, 16'd0}};
        directed_ops[22] = '{FUNC_CLEAR, 2'd2, 64'd0, 16'd0, 4'd0, 1'b1, NO_REPORT};
        directed_ops[23] = '{FUNC_READ, 2'd1, 64'd0, 16'd0, 4'd0, 1'b1, NO_REPORT};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < $size(directed_ops); k++)
        begin
            issue_op(directed_ops[k].fn, directed_ops[k].cat, directed_ops[k].sc,
                     directed_ops[k].tg, directed_ops[k].sl, directed_ops[k].typed,
                     directed_ops[k].want);
            hold_off($urandom_range(0, 2));
        end
        drain_reports();

        // Random traffic: mostly inserts and reads, rare clears
        no_idle = 1'b0;
        for (k = 0; k < RANDOM_OPS; k++)
        begin
            if (k % 150 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            if (k % 250 == 249)
                drain_reports();

            pick = $urandom_range(0, 99);
            if (pick < 55)
                fn = FUNC_INSERT;
            else if (pick < 93)
                fn = FUNC_READ;
            else if (pick < 98)
                fn = FUNC_UNUSED;
            else
                fn = FUNC_CLEAR;

            // small scores give ties and full tables; wide ones cover every bit
            pick = $urandom_range(0, 9);
            if (pick < 6)
                sc = 64'($urandom_range(0, 15));
            else if (pick == 6)
                sc = '0;
            else if (pick == 7)
                sc = SCORE_MAX;
            else
                sc = {$urandom, $urandom};

            sl = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(0, DEPTH - 1));

            issue_op(fn, 2'($urandom_range(0, CATS - 1)), sc, 16'($urandom), sl,
                     1'b0, NO_REPORT);

            if (no_idle)
                gap = 0;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    gap = 0;
                else if (pick < 90)
                    gap = $urandom_range(1, 3);
                else
                    gap = $urandom_range(5, 30);
            end
            hold_off(gap);
        end

        // Let the last reports arrive
        start <= 1'b0;
        guard = 0;
        while (pending_reports.size() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (8) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $error("%0d reports never arrived", pending_reports.size());
            errors++;
        end

        $display("Ran %0d commands: %0d inserts (%0d kept, %0d refused), %0d hit reads,",
                 $size(directed_ops) + RANDOM_OPS, n_inserts, n_kept, n_refused, n_hits);
        $display("%0d clears, with ties, extreme scores and out-of-range ranks.", n_clears);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5000000;
        $display("Timeout waiting for the block");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/tkss_pkg.sv
rtl/core/tkss_cell.sv
rtl/core/top_k_sorted_score_table.sv
tb/testbench.sv
